### hw/rtl/pfla_pkg.sv
// Shared types and constants for the page free-list allocator.
// No dependencies; imported by the allocator top level and its checker.
package pfla_pkg;

    localparam int ADDR_W    = 56;
    localparam int CNT_W     = 13;
    localparam int CFG_IDX_W = 8;

    // request kinds
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_COUNT = 8'd1;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] page_addr;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] result_addr;
        logic [1:0]        status;
        logic [CNT_W-1:0]  pages_free;
    } t_rsp;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [ADDR_W-1:0]    data;
    } t_cfg_wr;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

### hw/rtl/pfla_chan_if.sv
// Valid/ready channel interface, payload type set per instance.
// Used with the pfla_pkg structs for request, response and config beats.
interface pfla_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/page_free_list_allocator.sv
// Page free-list allocator: LIFO free stack of page indexes in one memory.
// Depends on pfla_pkg and pfla_chan_if.
//
// Usage:
//   i_req  (t_req beats): cmd alloc pops the last freed page, or else the
//          lowest page never handed out; cmd free pushes an aligned, in-pool
//          page address. Bad addresses give ST_INVALID and change nothing.
//   o_rsp  (t_rsp beats): one response per request, carrying the page address
//          (0 on free or failure), status and the free page count.
//   i_cfg  (t_cfg_wr beats): always ready. Writing pool base or page count
//          restarts the pool (stack empty, all pages free). Write only while
//          no request is in flight.
// Timing: a request is accepted in S_IDLE and its response is registered
//   at the end of S_EXEC, which waits while the response register is held.
//   The pop needs the link word for the current stack head; the registered
//   link memory read lands while the request is being accepted.
// Reset: pool base 0, page count 4096 (capped at MAX_PAGES), stack empty.
//   The link memory is not cleared; only pushed entries are ever read.
// Stall: the response register holds while o_rsp.ready is low; the block
//   can accept one more request and then waits to retire it.
module page_free_list_allocator #(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pfla_chan_if.sink    i_req,
    pfla_chan_if.source  o_rsp,
    pfla_chan_if.sink    i_cfg
);
    import pfla_pkg::*;

    localparam int IW = $clog2(MAX_PAGES);
    localparam int OB = $clog2(PAGE_BYTES);
    localparam int HW = ADDR_W - OB;
    localparam logic [CNT_W-1:0] RST_CNT =
        CNT_W'((MAX_PAGES < 4096) ? MAX_PAGES : 4096);

    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] c);
        clamp_cnt = (32'(c) > MAX_PAGES) ? CNT_W'(MAX_PAGES) : c;
    endfunction

    // state
    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_base, n_base;
    logic [CNT_W-1:0]   r_cfg_cnt, n_cfg_cnt;
    logic               r_head_vld, n_head_vld;
    logic [IW-1:0]      r_head_idx, n_head_idx;
    logic [CNT_W-1:0]   r_fresh, n_fresh;
    logic [CNT_W-1:0]   r_free_total, n_free_total;
    logic               r_cmd;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_rsp_vld, n_rsp_vld;
    t_rsp               r_rsp, n_rsp;

    // link memory: {next valid, next index} per stacked page
    logic [IW:0]        r_link_mem [MAX_PAGES];
    logic [IW:0]        r_link_rd;

    logic               w_push;
    logic [IW-1:0]      w_push_idx;

    logic [ADDR_W-1:0]  w_base;
    logic [CNT_W-1:0]   w_cnt;
    logic [ADDR_W-1:0]  w_page;
    logic [ADDR_W:0]    w_diff;
    logic               w_free_ok;
    logic               w_out_free;
    logic               w_cfg_wr;
    logic               w_req_acc;

    assign w_base    = {r_base[ADDR_W-1:OB], {OB{1'b0}}};
    assign w_cnt     = clamp_cnt(r_cfg_cnt);
    assign w_page    = r_head_vld ? ADDR_W'(r_head_idx) : ADDR_W'(r_fresh);
    assign w_diff    = {1'b0, r_addr} - {1'b0, w_base};
    // in pool: aligned, at or above base, page offset below the count
    assign w_free_ok = (r_addr[OB-1:0] == '0) && !w_diff[ADDR_W]
                     && (w_diff[ADDR_W-1:OB] < HW'(w_cnt));
    assign w_push_idx = w_diff[OB +: IW];

    assign w_out_free = !r_rsp_vld || o_rsp.ready;
    assign w_cfg_wr   = i_cfg.valid && i_cfg.ready;
    assign w_req_acc  = i_req.valid && i_req.ready;

    assign i_cfg.ready   = 1'b1;
    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_rsp_vld;
    assign o_rsp.payload = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_base       = r_base;
        n_cfg_cnt    = r_cfg_cnt;
        n_head_vld   = r_head_vld;
        n_head_idx   = r_head_idx;
        n_fresh      = r_fresh;
        n_free_total = r_free_total;
        n_rsp_vld    = r_rsp_vld && !o_rsp.ready;
        n_rsp        = r_rsp;
        w_push       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_req_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state             = S_IDLE;
                    n_rsp_vld           = 1'b1;
                    n_rsp.result_addr   = '0;
                    n_rsp.status        = ST_OK;
                    if (r_cmd == CMD_ALLOC) begin
                        if (r_head_vld || (r_fresh < w_cnt)) begin
                            n_rsp.result_addr = w_base + (w_page << OB);
                            if (r_head_vld) begin
                                n_head_vld = r_link_rd[IW];
                                n_head_idx = r_link_rd[IW-1:0];
                            end else begin
                                n_fresh = r_fresh + 1'b1;
                            end
                            if (r_free_total != '0) begin
                                n_free_total = r_free_total - 1'b1;
                            end
                        end else begin
                            n_rsp.status = ST_OOM;
                        end
                    end else begin
                        if (w_free_ok) begin
                            w_push     = 1'b1;
                            n_head_vld = 1'b1;
                            n_head_idx = w_push_idx;
                            if (r_free_total < w_cnt) begin
                                n_free_total = r_free_total + 1'b1;
                            end
                        end else begin
                            n_rsp.status = ST_INVALID;
                        end
                    end
                    n_rsp.pages_free = n_free_total;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // config writes must arrive only while idle (not enforced here); they restart the pool
        if (w_cfg_wr && ((i_cfg.payload.index == REG_POOL_BASE)
                      || (i_cfg.payload.index == REG_POOL_COUNT))) begin
            if (i_cfg.payload.index == REG_POOL_BASE) begin
                n_base       = i_cfg.payload.data;
                n_free_total = w_cnt;
            end else begin
                n_cfg_cnt    = i_cfg.payload.data[CNT_W-1:0];
                n_free_total = clamp_cnt(i_cfg.payload.data[CNT_W-1:0]);
            end
            n_head_vld = 1'b0;
            n_fresh    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= '0;
            r_cfg_cnt    <= CNT_W'(4096);
            r_head_vld   <= 1'b0;
            r_fresh      <= '0;
            r_free_total <= RST_CNT;
            r_rsp_vld    <= 1'b0;
        end else begin
            r_base       <= n_base;
            r_cfg_cnt    <= n_cfg_cnt;
            r_head_vld   <= n_head_vld;
            r_fresh      <= n_fresh;
            r_free_total <= n_free_total;
            r_rsp_vld    <= n_rsp_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_head_idx <= n_head_idx;
        r_rsp      <= n_rsp;
        if (w_req_acc) begin
            r_cmd  <= i_req.payload.cmd;
            r_addr <= i_req.payload.page_addr;
        end
    end

    // head only moves at the end of S_EXEC, and S_IDLE always follows,
    // so the read below has caught up before the next pop uses it
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_link_mem[w_push_idx] <= {r_head_vld, r_head_idx};
        end
        r_link_rd <= r_link_mem[r_head_idx];
    end

endmodule

### hw/rtl/pfla_checker.sv
// Port-level checks for page_free_list_allocator, attached by bind.
// Depends on pfla_pkg for the status codes and the response type.
module pfla_port_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input pfla_pkg::t_rsp               i_rsp
);
    import pfla_pkg::*;

    // a stalled response beat holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp))
        else $error("response changed while stalled");

    // one request at a time: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while one is in flight");

    // failures never carry an address
    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp.status == ST_OOM || i_rsp.status == ST_INVALID)
        |-> i_rsp.result_addr == '0)
        else $error("failed request returned an address");

    // an out-of-memory response reports no pages free
    a_oom_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp.status == ST_OOM |-> i_rsp.pages_free == '0)
        else $error("out of memory with pages reported free");

endmodule

bind page_free_list_allocator pfla_port_checker u_pfla_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.payload)
);
